### rtl/core/pfgp_pkg.sv
// Shared types and constants of the page framebuffer glyph plotter.
// Holds screen geometry, item kind codes, back-end commands and queue sizing.
// No dependencies.
package pfgp_pkg;

	localparam int SCREEN_WIDTH  = 128;
	localparam int SCREEN_HEIGHT = 64;
	localparam int SCREEN_PAGES  = (SCREEN_HEIGHT + 7) / 8;
	localparam int STORE_SIZE    = SCREEN_WIDTH * SCREEN_PAGES;
	localparam int ADDR_W        = $clog2(STORE_SIZE);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [15:0] PIXEL_BITS = 16'h8000;
	localparam logic [7:0]  CURSOR_SET_OFFSET = 8'd2;

	typedef enum logic [2:0] {
		KIND_FILL   = 3'd0,
		KIND_SET    = 3'd1,
		KIND_MOVE   = 3'd2,
		KIND_PIXEL  = 3'd3,
		KIND_GLYPH  = 3'd4,
		KIND_READ   = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_FILL,
		OP_PAINT,
		OP_READ
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EMIT,
		ST_FILL,
		ST_FETCH,
		ST_RMW,
		ST_READ_DATA
	} back_state_t;

	typedef struct packed {
		op_t               op;
		logic [ADDR_W-1:0] addr;
		logic [2:0]        bit_pos;
		logic              color;
		logic [15:0]       bits;
		logic [4:0]        count;
		logic              accepted;
		logic [7:0]        col;
		logic [7:0]        row;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

endpackage

### rtl/core/pfgp_front.sv
// Front end: accepts items, holds cursor and glyph registers, classifies items.
// Emits one back-end command per accepted item. Depends on pfgp_pkg.
module pfgp_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [2:0]            kind,
	input  logic [7:0]            x_pos,
	input  logic [7:0]            y_pos,
	input  logic signed [7:0]     dx,
	input  logic signed [7:0]     dy,
	input  logic                  color,
	input  logic [15:0]           row_bits,
	input  logic [5:0]            row_index,
	input  logic                  last_row,
	input  logic [9:0]            read_addr,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [6:0]            cfg_data,
	input  pfgp_pkg::fifo_status_t fifo_status,
	input  logic                  clearing,
	output logic                  push,
	output pfgp_pkg::cmd_t        cmd
);
	import pfgp_pkg::*;

	localparam logic [8:0] W9 = 9'(SCREEN_WIDTH);
	localparam logic [8:0] H9 = 9'(SCREEN_HEIGHT);

	logic [7:0] col_q, row_q;
	logic [4:0] gw_q;
	logic [6:0] gh_q;
	logic [7:0] col_n, row_n;
	logic [8:0] sum_w, sum_h, prow;
	logic       accept;

	assign busy   = fifo_status.full | clearing;
	assign accept = start & ~busy;
	assign push   = accept;

	assign sum_w = {1'b0, col_q} + 9'(gw_q);
	assign sum_h = {1'b0, row_q} + 9'(gh_q);
	assign prow  = {1'b0, row_q} + 9'(row_index);

	always_comb begin
		col_n        = col_q;
		row_n        = row_q;
		cmd.op       = OP_NONE;
		cmd.addr     = '0;
		cmd.bit_pos  = '0;
		cmd.color    = color;
		cmd.bits     = PIXEL_BITS;
		cmd.count    = 5'd1;
		cmd.accepted = 1'b1;
		case (kind_t'(kind))
			KIND_FILL: begin
				cmd.op = OP_FILL;
			end
			KIND_SET: begin
				col_n = x_pos + CURSOR_SET_OFFSET;
				row_n = y_pos;
			end
			KIND_MOVE: begin
				col_n = col_q + $unsigned(dx);
				row_n = row_q + $unsigned(dy);
			end
			KIND_PIXEL: begin
				if ({1'b0, x_pos} < W9 && {1'b0, y_pos} < H9) begin
					cmd.op      = OP_PAINT;
					cmd.addr    = ADDR_W'(int'(y_pos[7:3]) * SCREEN_WIDTH + int'(x_pos));
					cmd.bit_pos = y_pos[2:0];
				end else begin
					cmd.accepted = 1'b0;
				end
			end
			KIND_GLYPH: begin
				if (sum_w >= W9 || sum_h >= H9) begin
					cmd.accepted = 1'b0;
				end else begin
					if (prow < H9 && gw_q != 5'd0) begin
						cmd.op      = OP_PAINT;
						cmd.addr    = ADDR_W'(int'(prow[7:3]) * SCREEN_WIDTH + int'(col_q));
						cmd.bit_pos = prow[2:0];
						cmd.bits    = row_bits;
						cmd.count   = gw_q;
					end
					if (last_row) begin
						col_n = col_q + 8'(gw_q);
					end
				end
			end
			KIND_READ: begin
				if (int'(read_addr) < STORE_SIZE) begin
					cmd.op   = OP_READ;
					cmd.addr = ADDR_W'(read_addr);
				end
			end
			default: begin
				cmd.accepted = 1'b0;
			end
		endcase
		cmd.col = col_n;
		cmd.row = row_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			gw_q  <= 5'd11;
			gh_q  <= 7'd18;
		end else begin
			if (accept) begin
				col_q <= col_n;
				row_q <= row_n;
			end
			if (cfg_we) begin
				if (cfg_index) begin
					gh_q <= cfg_data;
				end else begin
					gw_q <= cfg_data[4:0];
				end
			end
		end
	end

endmodule

### rtl/core/pfgp_cmd_fifo.sv
// Short command queue between front end and back end.
// Register-based, depth from pfgp_pkg. Depends on pfgp_pkg.
module pfgp_cmd_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  pfgp_pkg::cmd_t         push_cmd,
	input  logic                   pop,
	output pfgp_pkg::cmd_t         head,
	output pfgp_pkg::fifo_status_t status
);
	import pfgp_pkg::*;

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q, rptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	assign head         = entry_q[rptr_q];
	assign status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= next_ptr(wptr_q);
			end
			if (pop) begin
				rptr_q <= next_ptr(rptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !status.full)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !status.empty)
		else $error("pop from empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");
	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not follow push");

endmodule

### rtl/core/pfgp_back.sv
// Back end: frame store, clearing pass, fill sweep, read-modify-write painter.
// Pops commands from the queue and drives the result ports. Depends on pfgp_pkg.
module pfgp_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pfgp_pkg::fifo_status_t fifo_status,
	input  pfgp_pkg::cmd_t         head,
	output logic                   pop,
	output logic                   clearing,
	output logic                   done,
	output logic [7:0]             read_data,
	output logic                   accepted,
	output logic [7:0]             cursor_col,
	output logic [7:0]             cursor_row
);
	import pfgp_pkg::*;

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_SIZE - 1);

	back_state_t       st_q, st_n;
	cmd_t              cmd_q;
	logic [ADDR_W-1:0] addr_q;
	logic [4:0]        cnt_q;
	logic [15:0]       shift_q;

	logic [7:0]        mem [STORE_SIZE];
	logic [7:0]        rd_q;
	logic              mem_we, rd_en, finish;
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0]        wd, mask, fin_data;
	logic              paint, sweep_last, col_last;

	assign sweep_last = (addr_q == LAST_ADDR);
	assign col_last   = (cnt_q == 5'd1);
	assign mask       = 8'd1 << cmd_q.bit_pos;
	assign paint      = shift_q[15] ? cmd_q.color : ~cmd_q.color;

	always_comb begin
		st_n = st_q;
		case (st_q)
			ST_CLEAR: begin
				if (sweep_last) begin
					st_n = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (!fifo_status.empty) begin
					case (head.op)
						OP_FILL:  st_n = ST_FILL;
						OP_PAINT: st_n = ST_FETCH;
						OP_READ:  st_n = ST_FETCH;
						default:  st_n = ST_EMIT;
					endcase
				end
			end
			ST_EMIT: st_n = ST_IDLE;
			ST_FILL: begin
				if (sweep_last) begin
					st_n = ST_IDLE;
				end
			end
			ST_FETCH: st_n = (cmd_q.op == OP_READ) ? ST_READ_DATA : ST_RMW;
			ST_RMW: begin
				if (col_last) begin
					st_n = ST_IDLE;
				end
			end
			ST_READ_DATA: st_n = ST_IDLE;
			default: st_n = ST_IDLE;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		mem_we   = 1'b0;
		wd       = '0;
		rd_en    = 1'b0;
		rd_addr  = addr_q;
		finish   = 1'b0;
		fin_data = '0;
		case (st_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_IDLE: begin
				pop = ~fifo_status.empty;
			end
			ST_EMIT: begin
				finish = 1'b1;
			end
			ST_FILL: begin
				mem_we = 1'b1;
				wd     = {8{cmd_q.color}};
				finish = sweep_last;
			end
			ST_FETCH: begin
				rd_en = 1'b1;
			end
			ST_RMW: begin
				mem_we  = 1'b1;
				wd      = paint ? (rd_q | mask) : (rd_q & ~mask);
				rd_en   = ~col_last;
				rd_addr = addr_q + 1'b1;
				finish  = col_last;
			end
			ST_READ_DATA: begin
				finish   = 1'b1;
				fin_data = rd_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr_q] <= wd;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_CLEAR;
			addr_q <= '0;
		end else begin
			st_q <= st_n;
			case (st_q)
				ST_CLEAR, ST_FILL: begin
					addr_q <= sweep_last ? '0 : addr_q + 1'b1;
				end
				ST_IDLE: begin
					if (pop) begin
						addr_q <= (head.op == OP_FILL) ? '0 : head.addr;
					end
				end
				ST_RMW: begin
					addr_q <= addr_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q   <= head;
			cnt_q   <= head.count;
			shift_q <= head.bits;
		end else if (st_q == ST_RMW) begin
			cnt_q   <= cnt_q - 1'b1;
			shift_q <= {shift_q[14:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= finish;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			read_data  <= fin_data;
			accepted   <= cmd_q.accepted;
			cursor_col <= cmd_q.col;
			cursor_row <= cmd_q.row;
		end
	end

	assign clearing = (st_q == ST_CLEAR);

endmodule

### rtl/core/page_framebuffer_glyph_plotter.sv
// Page framebuffer glyph plotter: every accepted item (cursor, clipped, rejected, pixel, read,
// glyph row or fill) gives one result, signalled on done; the back end works on one item at a
// time, and a two-entry queue lets the next item be taken while one runs; done pulses one cycle.
// After reset a clearing pass zeroes all STORE_SIZE (1024) bytes of the store, busy high.
module page_framebuffer_glyph_plotter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [2:0]        kind,
	input  logic [7:0]        x_pos,
	input  logic [7:0]        y_pos,
	input  logic signed [7:0] dx,
	input  logic signed [7:0] dy,
	input  logic              color,
	input  logic [15:0]       row_bits,
	input  logic [5:0]        row_index,
	input  logic              last_row,
	input  logic [9:0]        read_addr,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [6:0]        cfg_data,
	output logic              done,
	output logic [7:0]        read_data,
	output logic              accepted,
	output logic [7:0]        cursor_col,
	output logic [7:0]        cursor_row
);
	import pfgp_pkg::*;

	fifo_status_t fifo_status;
	cmd_t         push_cmd, head;
	logic         push, pop, clearing;

	pfgp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.kind        (kind),
		.x_pos       (x_pos),
		.y_pos       (y_pos),
		.dx          (dx),
		.dy          (dy),
		.color       (color),
		.row_bits    (row_bits),
		.row_index   (row_index),
		.last_row    (last_row),
		.read_addr   (read_addr),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fifo_status (fifo_status),
		.clearing    (clearing),
		.push        (push),
		.cmd         (push_cmd)
	);

	pfgp_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.status   (fifo_status)
	);

	pfgp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.fifo_status (fifo_status),
		.head        (head),
		.pop         (pop),
		.clearing    (clearing),
		.done        (done),
		.read_data   (read_data),
		.accepted    (accepted),
		.cursor_col  (cursor_col),
		.cursor_row  (cursor_row)
	);

endmodule
